### src/sfs_pkg.sv
`default_nettype none
package sfs_pkg;

  // Table geometry
  localparam int FRAMES  = 64;
  localparam int IDX_W   = $clog2(FRAMES);
  localparam int CNT_W   = $clog2(FRAMES + 1);

  // Fixed field widths
  localparam int CMD_W   = 4;
  localparam int FNUM_W  = 6;
  localparam int DELAY_W = 32;
  localparam int COORD_W = 16;
  localparam int REP_W   = 17;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK       = 4'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_PAUSE      = 4'd3;
  localparam logic [CMD_W-1:0] CMD_RESUME     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RESTART    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_GOTO       = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SET_REPEAT = 4'd7;
  localparam logic [CMD_W-1:0] CMD_SET_DELAY  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_SET_BOUNDS = 4'd9;

  // Repeat count meaning loop forever (-1 in 17 bits)
  localparam logic [REP_W-1:0]   REP_FOREVER = '1;
  // Elapsed counter saturation value
  localparam logic [DELAY_W-1:0] ELAPSED_MAX = '1;

  // Source rectangle as stored in the frame table
  typedef struct packed {
    logic [COORD_W-1:0] h;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } rect_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ctrl_t;

endpackage
`default_nettype wire

### src/sfs_if.sv
`default_nettype none
// Input item channel
interface sfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [sfs_pkg::CMD_W-1:0]     cmd;
  logic [sfs_pkg::FNUM_W-1:0]    frame_number;
  logic [sfs_pkg::DELAY_W-1:0]   frame_delay;
  logic [sfs_pkg::COORD_W-1:0]   src_x;
  logic [sfs_pkg::COORD_W-1:0]   src_y;
  logic [sfs_pkg::COORD_W-1:0]   src_w;
  logic [sfs_pkg::COORD_W-1:0]   src_h;
  logic signed [sfs_pkg::REP_W-1:0] repeat_value;

  modport source (output valid, cmd, frame_number, frame_delay, src_x, src_y, src_w, src_h,
                  repeat_value, input ready);
  modport sink   (input valid, cmd, frame_number, frame_delay, src_x, src_y, src_w, src_h,
                  repeat_value, output ready);
endinterface

// Result channel
interface sfs_out_if;
  logic                        valid;
  logic                        ready;
  logic [sfs_pkg::IDX_W-1:0]   current_frame;
  logic [sfs_pkg::COORD_W-1:0] shown_x;
  logic [sfs_pkg::COORD_W-1:0] shown_y;
  logic [sfs_pkg::COORD_W-1:0] shown_w;
  logic [sfs_pkg::COORD_W-1:0] shown_h;
  logic [sfs_pkg::CNT_W-1:0]   frame_total;
  logic                        is_paused;
  logic                        is_done;
  logic                        frame_advanced;

  modport source (output valid, current_frame, shown_x, shown_y, shown_w, shown_h, frame_total,
                  is_paused, is_done, frame_advanced, input ready);
  modport sink   (input valid, current_frame, shown_x, shown_y, shown_w, shown_h, frame_total,
                  is_paused, is_done, frame_advanced, output ready);
endinterface
`default_nettype wire

### src/sprite_frame_sequencer.sv
// Sprite animation frame sequencer.
// in_ch carries one command per transfer: tick, append, clear, pause, resume,
// restart, goto, set repeats, set delay or set bounds. Every accepted item
// gives exactly one result on out_ch: the current frame index, its source
// rectangle (zero while the table is empty), the frame count, the paused and
// done flags and whether this item advanced the frame.
// Timing: an item is taken in the idle state; the update step (S_EXEC) updates
// the state and writes the frame tables, the read step (S_READ) reads the
// rectangle of the new current frame, and the result is loaded in the output
// step (S_OUT). The block takes no new item until it is back in the idle
// state; the read step is needed because the registered table read must
// follow the update of the frame index.
// The result register holds a finished result while a new item is taken and
// worked on; with out_ch stalled the block waits in its output step until
// the result is taken, and in_ch.ready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the table, clears index, elapsed
// ticks, repeat count, paused and done flags, and drops any pending result.
// Table entries are not cleared; only entries below the frame count are read.
`default_nettype none
module sprite_frame_sequencer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sfs_in_if.sink     in_ch,
  sfs_out_if.source  out_ch
);

  sfs_pkg::ctrl_t ctrl;

  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctrl      (ctrl)
  );

  sfs_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .in_cmd             (in_ch.cmd),
    .in_frame_number    (in_ch.frame_number),
    .in_frame_delay     (in_ch.frame_delay),
    .in_src_x           (in_ch.src_x),
    .in_src_y           (in_ch.src_y),
    .in_src_w           (in_ch.src_w),
    .in_src_h           (in_ch.src_h),
    .in_repeat_value    (in_ch.repeat_value),
    .out_current_frame  (out_ch.current_frame),
    .out_shown_x        (out_ch.shown_x),
    .out_shown_y        (out_ch.shown_y),
    .out_shown_w        (out_ch.shown_w),
    .out_shown_h        (out_ch.shown_h),
    .out_frame_total    (out_ch.frame_total),
    .out_is_paused      (out_ch.is_paused),
    .out_is_done        (out_ch.is_done),
    .out_frame_advanced (out_ch.frame_advanced)
  );

endmodule
`default_nettype wire

### src/sfs_ctrl.sv
`default_nettype none
module sfs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sfs_pkg::ctrl_t      ctrl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Command decode
  always_comb begin
    ctrl.capture = (state_r == S_IDLE) && in_valid;
    ctrl.exec    = (state_r == S_EXEC);
    ctrl.load    = (state_r == S_OUT) && (!out_valid_r || out_ready);
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_READ;
      S_READ: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A captured item always moves on to the update step
  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.capture |=> ctrl.exec)
    else $error("captured item not executed");

  // A read step is always followed by the output step
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_OUT))
    else $error("read step not followed by output step");

  // Result register fills only from the output step
  a_valid_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result valid without output step");

endmodule
`default_nettype wire

### src/sfs_dpath.sv
`default_nettype none
module sfs_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sfs_pkg::ctrl_t                ctrl,
  input  wire logic [sfs_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [sfs_pkg::FNUM_W-1:0]    in_frame_number,
  input  wire logic [sfs_pkg::DELAY_W-1:0]   in_frame_delay,
  input  wire logic [sfs_pkg::COORD_W-1:0]   in_src_x,
  input  wire logic [sfs_pkg::COORD_W-1:0]   in_src_y,
  input  wire logic [sfs_pkg::COORD_W-1:0]   in_src_w,
  input  wire logic [sfs_pkg::COORD_W-1:0]   in_src_h,
  input  wire logic signed [sfs_pkg::REP_W-1:0] in_repeat_value,
  output logic [sfs_pkg::IDX_W-1:0]          out_current_frame,
  output logic [sfs_pkg::COORD_W-1:0]        out_shown_x,
  output logic [sfs_pkg::COORD_W-1:0]        out_shown_y,
  output logic [sfs_pkg::COORD_W-1:0]        out_shown_w,
  output logic [sfs_pkg::COORD_W-1:0]        out_shown_h,
  output logic [sfs_pkg::CNT_W-1:0]          out_frame_total,
  output logic                               out_is_paused,
  output logic                               out_is_done,
  output logic                               out_frame_advanced
);

  // Captured item
  logic [sfs_pkg::CMD_W-1:0]   cmd_r;
  logic [sfs_pkg::FNUM_W-1:0]  fnum_r;
  logic [sfs_pkg::DELAY_W-1:0] delay_r;
  sfs_pkg::rect_t              rect_in_r;
  logic [sfs_pkg::REP_W-1:0]   rep_r;

  // Sequencer state
  logic [sfs_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [sfs_pkg::IDX_W-1:0]   index_r, index_nxt;
  logic [sfs_pkg::DELAY_W-1:0] elapsed_r, elapsed_nxt;
  logic [sfs_pkg::REP_W-1:0]   repeats_r, repeats_nxt;
  logic                        paused_r, paused_nxt;
  logic                        done_r, done_nxt;
  logic                        adv_r, adv_nxt;

  // Frame tables
  sfs_pkg::rect_t              rect_mem [sfs_pkg::FRAMES];
  logic [sfs_pkg::DELAY_W-1:0] delay_mem [sfs_pkg::FRAMES];
  sfs_pkg::rect_t              rect_q;
  logic [sfs_pkg::DELAY_W-1:0] delay_q;

  logic                        rect_we, delay_we;
  logic [sfs_pkg::IDX_W-1:0]   rect_wa, delay_wa;

  logic [sfs_pkg::DELAY_W-1:0] el_inc;
  logic [sfs_pkg::CNT_W-1:0]   idx_inc;
  logic [sfs_pkg::CNT_W-1:0]   fnum_ext;
  logic                        fnum_ok;
  logic                        tick_run;

  // Item capture
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r       <= in_cmd;
      fnum_r      <= in_frame_number;
      delay_r     <= in_frame_delay;
      rect_in_r.x <= in_src_x;
      rect_in_r.y <= in_src_y;
      rect_in_r.w <= in_src_w;
      rect_in_r.h <= in_src_h;
      rep_r       <= in_repeat_value;
    end
  end

  assign el_inc   = (elapsed_r == sfs_pkg::ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign idx_inc  = {1'b0, index_r} + 1'b1;
  assign fnum_ext = sfs_pkg::CNT_W'(fnum_r);
  assign fnum_ok  = fnum_ext < count_r;
  assign tick_run = !paused_r && !done_r && (count_r != '0);

  // Command execution
  always_comb begin
    count_nxt   = count_r;
    index_nxt   = index_r;
    elapsed_nxt = elapsed_r;
    repeats_nxt = repeats_r;
    paused_nxt  = paused_r;
    done_nxt    = done_r;
    adv_nxt     = adv_r;
    rect_we     = 1'b0;
    delay_we    = 1'b0;
    rect_wa     = fnum_r[sfs_pkg::IDX_W-1:0];
    delay_wa    = fnum_r[sfs_pkg::IDX_W-1:0];
    if (ctrl.exec) begin
      adv_nxt = 1'b0;
      case (cmd_r)
        sfs_pkg::CMD_TICK: begin
          if (tick_run) begin
            elapsed_nxt = el_inc;
            if (delay_q < el_inc) begin
              adv_nxt     = 1'b1;
              elapsed_nxt = '0;
              if (idx_inc >= count_r) begin
                index_nxt = '0;
                if (repeats_r != sfs_pkg::REP_FOREVER) begin
                  if (repeats_r == '0) begin
                    done_nxt   = 1'b1;
                    paused_nxt = 1'b1;
                  end else begin
                    repeats_nxt = repeats_r - 1'b1;
                  end
                end
              end else begin
                index_nxt = idx_inc[sfs_pkg::IDX_W-1:0];
              end
            end
          end
        end
        sfs_pkg::CMD_APPEND: begin
          if (count_r < sfs_pkg::CNT_W'(sfs_pkg::FRAMES)) begin
            rect_we   = 1'b1;
            delay_we  = 1'b1;
            rect_wa   = count_r[sfs_pkg::IDX_W-1:0];
            delay_wa  = count_r[sfs_pkg::IDX_W-1:0];
            count_nxt = count_r + 1'b1;
          end
        end
        sfs_pkg::CMD_CLEAR: begin
          count_nxt   = '0;
          index_nxt   = '0;
          elapsed_nxt = '0;
        end
        sfs_pkg::CMD_PAUSE: paused_nxt = 1'b1;
        sfs_pkg::CMD_RESUME: begin
          paused_nxt  = 1'b0;
          elapsed_nxt = '0;
        end
        sfs_pkg::CMD_RESTART: begin
          index_nxt   = '0;
          done_nxt    = 1'b0;
          paused_nxt  = 1'b0;
          elapsed_nxt = '0;
        end
        sfs_pkg::CMD_GOTO: begin
          if (fnum_ok) begin
            index_nxt   = fnum_r[sfs_pkg::IDX_W-1:0];
            elapsed_nxt = '0;
          end
        end
        sfs_pkg::CMD_SET_REPEAT: repeats_nxt = rep_r;
        sfs_pkg::CMD_SET_DELAY:  delay_we = fnum_ok;
        sfs_pkg::CMD_SET_BOUNDS: rect_we  = fnum_ok;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      index_r   <= '0;
      elapsed_r <= '0;
      repeats_r <= '0;
      paused_r  <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      index_r   <= index_nxt;
      elapsed_r <= elapsed_nxt;
      repeats_r <= repeats_nxt;
      paused_r  <= paused_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    adv_r <= adv_nxt;
  end

  // Frame tables: one write port each, registered read at the current index
  always_ff @(posedge clk) begin
    if (rect_we) rect_mem[rect_wa] <= rect_in_r;
    rect_q <= rect_mem[index_r];
  end

  always_ff @(posedge clk) begin
    if (delay_we) delay_mem[delay_wa] <= delay_r;
    delay_q <= delay_mem[index_r];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_current_frame  <= index_r;
      out_shown_x        <= (count_r != '0) ? rect_q.x : '0;
      out_shown_y        <= (count_r != '0) ? rect_q.y : '0;
      out_shown_w        <= (count_r != '0) ? rect_q.w : '0;
      out_shown_h        <= (count_r != '0) ? rect_q.h : '0;
      out_frame_total    <= count_r;
      out_is_paused      <= paused_r;
      out_is_done        <= done_r;
      out_frame_advanced <= adv_r;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sfs_pkg::CNT_W'(sfs_pkg::FRAMES))
    else $error("frame count beyond table");

  a_index_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> ({1'b0, index_r} < count_r))
    else $error("frame index outside table");

  a_index_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (index_r == '0))
    else $error("nonzero index with empty table");

  a_done_paused: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.exec && cmd_r == sfs_pkg::CMD_TICK && done_nxt && !done_r) |=> paused_r)
    else $error("done set without pause");

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;

  // Command codes the block has no use for
  localparam logic [sfs_pkg::CMD_W-1:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [sfs_pkg::CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

  // One command as driven onto in_ch
  typedef struct packed {
    logic [sfs_pkg::CMD_W-1:0]        cmd;
    logic [sfs_pkg::FNUM_W-1:0]       fnum;
    logic [sfs_pkg::DELAY_W-1:0]      delay;
    sfs_pkg::rect_t                   rect;
    logic signed [sfs_pkg::REP_W-1:0] rep;
  } anim_cmd_t;

  // What out_ch should show after one command
  typedef struct packed {
    logic [sfs_pkg::IDX_W-1:0] frame;
    sfs_pkg::rect_t            rect;
    logic [sfs_pkg::CNT_W-1:0] total;
    logic                      paused;
    logic                      done;
    logic                      advanced;
  } frame_view_t;

  logic clk;
  logic rst_n;

  sfs_in_if  in_if ();
  sfs_out_if out_if ();

  sprite_frame_sequencer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Animation state as the block should hold it
  sfs_pkg::rect_t              anim_rects [sfs_pkg::FRAMES];
  logic [sfs_pkg::DELAY_W-1:0] anim_delays [sfs_pkg::FRAMES];
  logic [sfs_pkg::CNT_W-1:0]   anim_count   = '0;
  logic [sfs_pkg::IDX_W-1:0]   anim_idx     = '0;
  logic [sfs_pkg::DELAY_W-1:0] anim_elapsed = '0;
  logic [sfs_pkg::REP_W-1:0]   anim_repeats = '0;
  logic                        anim_paused  = 1'b0;
  logic                        anim_done    = 1'b0;

  frame_view_t pending_views [$];
  int          fail_count    = 0;
  int          cycle_count   = 0;
  int          rx_hold_cycles = 0;
  logic        src_idle_en   = 1'b1;
  logic        rx_idle_en    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // One tick of animation time; returns 1 when the frame moves on
  function automatic logic tick_frame();
    if (anim_paused || anim_done || anim_count == '0) return 1'b0;
    if (anim_elapsed != sfs_pkg::ELAPSED_MAX) anim_elapsed = anim_elapsed + 1'b1;
    if (anim_idx >= anim_count) anim_idx = '0;
    if (anim_delays[anim_idx] >= anim_elapsed) return 1'b0;
    anim_elapsed = '0;
    // wrap past the last frame, then spend one repetition
    if (int'(anim_idx) + 1 >= int'(anim_count)) begin
      if (anim_repeats != sfs_pkg::REP_FOREVER) begin
        if (anim_repeats == '0) begin
          anim_done   = 1'b1;
          anim_paused = 1'b1;
        end else begin
          anim_repeats = anim_repeats - 1'b1;
        end
      end
      anim_idx = '0;
    end else begin
      anim_idx = anim_idx + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic frame_view_t next_view(input anim_cmd_t c);
    frame_view_t v;
    logic        moved;
    moved = 1'b0;
    case (c.cmd)
      sfs_pkg::CMD_TICK: moved = tick_frame();
      sfs_pkg::CMD_APPEND: begin
        if (anim_count < sfs_pkg::FRAMES) begin
          anim_rects[anim_count[sfs_pkg::IDX_W-1:0]]  = c.rect;
          anim_delays[anim_count[sfs_pkg::IDX_W-1:0]] = c.delay;
          anim_count = anim_count + 1'b1;
        end
      end
      sfs_pkg::CMD_CLEAR: begin
        anim_count   = '0;
        anim_idx     = '0;
        anim_elapsed = '0;
      end
      sfs_pkg::CMD_PAUSE: anim_paused = 1'b1;
      sfs_pkg::CMD_RESUME: begin
        anim_paused  = 1'b0;
        anim_elapsed = '0;
      end
      sfs_pkg::CMD_RESTART: begin
        anim_idx     = '0;
        anim_done    = 1'b0;
        anim_paused  = 1'b0;
        anim_elapsed = '0;
      end
      sfs_pkg::CMD_GOTO: begin
        if (c.fnum < anim_count) begin
          anim_idx     = c.fnum;
          anim_elapsed = '0;
        end
      end
      sfs_pkg::CMD_SET_REPEAT: anim_repeats = c.rep;
      sfs_pkg::CMD_SET_DELAY: if (c.fnum < anim_count) anim_delays[c.fnum] = c.delay;
      sfs_pkg::CMD_SET_BOUNDS: if (c.fnum < anim_count) anim_rects[c.fnum] = c.rect;
      default: ;
    endcase
    v.frame    = anim_idx;
    v.rect     = (anim_count != '0 && anim_idx < anim_count) ? anim_rects[anim_idx] : '0;
    v.total    = anim_count;
    v.paused   = anim_paused;
    v.done     = anim_done;
    v.advanced = moved;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Item generation
  // ---------------------------------------------------------------------------

  function automatic anim_cmd_t random_fields(input logic [sfs_pkg::CMD_W-1:0] op);
    anim_cmd_t c;
    c.cmd   = op;
    c.fnum  = sfs_pkg::FNUM_W'($urandom);
    c.delay = $urandom;
    c.rect  = {$urandom, $urandom};
    c.rep   = sfs_pkg::REP_W'($urandom);
    return c;
  endfunction

  // short delays mostly, so that frames really advance
  function automatic logic [sfs_pkg::DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: return sfs_pkg::DELAY_W'($urandom_range(0, 3));
      5:             return sfs_pkg::DELAY_W'($urandom_range(0, 20));
      6:             return $urandom;
      default:       return sfs_pkg::ELAPSED_MAX;
    endcase
  endfunction

  function automatic logic signed [sfs_pkg::REP_W-1:0] pick_repeats();
    case ($urandom_range(0, 5))
      0:       return sfs_pkg::REP_FOREVER;
      1:       return '0;
      2, 3:    return sfs_pkg::REP_W'($urandom_range(1, 3));
      4:       return sfs_pkg::REP_W'(-$urandom_range(2, 5));
      default: return sfs_pkg::REP_W'($urandom);
    endcase
  endfunction

  // an index near the table, sometimes one past it, now and then anywhere
  function automatic logic [sfs_pkg::FNUM_W-1:0] pick_index(input int nf);
    int idx;
    idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, sfs_pkg::FRAMES - 1)
                                      : $urandom_range(0, nf);
    if (idx > sfs_pkg::FRAMES - 1) idx = sfs_pkg::FRAMES - 1;
    return sfs_pkg::FNUM_W'(idx);
  endfunction

  // one command while an animation plays: ticks mostly, controls now and then
  function automatic anim_cmd_t play_item(input int nf);
    anim_cmd_t c;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      c = random_fields(sfs_pkg::CMD_TICK);
    end else if (pick < 73) begin
      c = random_fields(sfs_pkg::CMD_PAUSE);
    end else if (pick < 77) begin
      c = random_fields(sfs_pkg::CMD_RESUME);
    end else if (pick < 80) begin
      c = random_fields(sfs_pkg::CMD_RESTART);
    end else if (pick < 85) begin
      c = random_fields(sfs_pkg::CMD_GOTO);
      c.fnum = pick_index(nf);
    end else if (pick < 89) begin
      c = random_fields(sfs_pkg::CMD_SET_DELAY);
      c.fnum  = pick_index(nf);
      c.delay = pick_delay();
    end else if (pick < 93) begin
      c = random_fields(sfs_pkg::CMD_SET_BOUNDS);
      c.fnum = pick_index(nf);
    end else if (pick < 95) begin
      c = random_fields(sfs_pkg::CMD_SET_REPEAT);
      c.rep = pick_repeats();
    end else if (pick < 97) begin
      c = random_fields(sfs_pkg::CMD_APPEND);
      c.delay = pick_delay();
    end else if (pick < 98) begin
      c = random_fields(sfs_pkg::CMD_CLEAR);
    end else begin
      c = random_fields(sfs_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one command, wait for its transfer, then record the expected view
  task automatic push_cmd(input anim_cmd_t c);
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.cmd          <= c.cmd;
    in_if.frame_number <= c.fnum;
    in_if.frame_delay  <= c.delay;
    in_if.src_x        <= c.rect.x;
    in_if.src_y        <= c.rect.y;
    in_if.src_w        <= c.rect.w;
    in_if.src_h        <= c.rect.h;
    in_if.repeat_value <= c.rep;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_views.insert(pending_views.size(), next_view(c));
  endtask

  task automatic send_simple(input logic [sfs_pkg::CMD_W-1:0] op);
    push_cmd(random_fields(op));
  endtask

  task automatic send_append(input logic [sfs_pkg::DELAY_W-1:0] delay,
                             input sfs_pkg::rect_t rect);
    anim_cmd_t c;
    c = random_fields(sfs_pkg::CMD_APPEND);
    c.delay = delay;
    c.rect  = rect;
    push_cmd(c);
  endtask

  task automatic send_at(input logic [sfs_pkg::CMD_W-1:0] op,
                         input logic [sfs_pkg::FNUM_W-1:0] fnum,
                         input logic [sfs_pkg::DELAY_W-1:0] delay,
                         input sfs_pkg::rect_t rect);
    anim_cmd_t c;
    c = random_fields(op);
    c.fnum  = fnum;
    c.delay = delay;
    c.rect  = rect;
    push_cmd(c);
  endtask

  task automatic send_repeats(input logic signed [sfs_pkg::REP_W-1:0] rep);
    anim_cmd_t c;
    c = random_fields(sfs_pkg::CMD_SET_REPEAT);
    c.rep = rep;
    push_cmd(c);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Commands on an empty table: nothing counts, indexed commands are dropped
  task automatic test_empty_table();
    send_simple(sfs_pkg::CMD_TICK);
    send_at(sfs_pkg::CMD_GOTO, '0, '0, '1);
    send_at(sfs_pkg::CMD_SET_DELAY, '0, '0, '0);
    send_at(sfs_pkg::CMD_SET_BOUNDS, '1, '1, '1);
    send_simple(sfs_pkg::CMD_PAUSE);
    send_simple(sfs_pkg::CMD_TICK);
    send_simple(sfs_pkg::CMD_RESUME);
    send_simple(CMD_UNUSED_LO);
    send_simple(CMD_UNUSED_HI);
    send_simple(sfs_pkg::CMD_RESTART);
  endtask

  // Advance, wrap, repeat count down to done, then the controls
  task automatic test_playback();
    send_simple(sfs_pkg::CMD_CLEAR);
    send_append('0, '1);
    send_append(sfs_pkg::DELAY_W'(1), '0);
    send_append(sfs_pkg::ELAPSED_MAX, {16'h5A5A, 16'hA5A5, 16'h0000, 16'hFFFF});
    send_repeats(sfs_pkg::REP_W'(1));
    repeat (5) send_simple(sfs_pkg::CMD_TICK);       // last frame never runs out
    send_at(sfs_pkg::CMD_SET_DELAY, sfs_pkg::FNUM_W'(2), '0, '0);
    repeat (6) send_simple(sfs_pkg::CMD_TICK);       // second pass ends in done
    send_simple(sfs_pkg::CMD_RESUME);                // done stays set
    send_simple(sfs_pkg::CMD_TICK);
    send_simple(sfs_pkg::CMD_RESTART);
    send_at(sfs_pkg::CMD_SET_BOUNDS, sfs_pkg::FNUM_W'(1), '0, {$urandom, $urandom});
    send_at(sfs_pkg::CMD_GOTO, sfs_pkg::FNUM_W'(2), '0, '0);
    send_at(sfs_pkg::CMD_GOTO, sfs_pkg::FNUM_W'(5), '0, '0);  // past the table, ignored
    send_repeats(sfs_pkg::REP_W'(-2));
    repeat (3) send_simple(sfs_pkg::CMD_TICK);
    send_simple(sfs_pkg::CMD_CLEAR);
  endtask

  // Fill all frames, one append too many, play across the top index
  task automatic test_full_table();
    send_simple(sfs_pkg::CMD_CLEAR);
    repeat (sfs_pkg::FRAMES)
      send_append(sfs_pkg::DELAY_W'($urandom_range(0, 2)), {$urandom, $urandom});
    send_append('0, '1);
    send_at(sfs_pkg::CMD_GOTO, sfs_pkg::FNUM_W'(sfs_pkg::FRAMES - 1), '0, '0);
    send_at(sfs_pkg::CMD_SET_BOUNDS, sfs_pkg::FNUM_W'(sfs_pkg::FRAMES - 1), '0, '1);
    send_repeats('0);
    send_simple(sfs_pkg::CMD_RESTART);
    repeat (8) send_simple(sfs_pkg::CMD_TICK);
    send_at(sfs_pkg::CMD_GOTO, sfs_pkg::FNUM_W'(sfs_pkg::FRAMES - 2), '0, '0);
    send_at(sfs_pkg::CMD_SET_DELAY, sfs_pkg::FNUM_W'(sfs_pkg::FRAMES - 1), '0, '0);
    repeat (8) send_simple(sfs_pkg::CMD_TICK);
  endtask

  // Receiver holds off a long time while commands keep coming
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    send_simple(sfs_pkg::CMD_CLEAR);
    repeat (3) send_append(sfs_pkg::DELAY_W'($urandom_range(0, 1)), {$urandom, $urandom});
    send_repeats(sfs_pkg::REP_FOREVER);
    send_simple(sfs_pkg::CMD_RESTART);
    repeat (10) send_simple(sfs_pkg::CMD_TICK);
    src_idle_en = 1'b1;
  endtask

  // Random animations: build a table, set repeats, play with mixed controls
  task automatic test_random_play(input int n_items, input logic with_idle);
    int stop_at;
    int nf;
    int n_play;
    stop_at = pending_views.size() + n_items;
    n_items = 0;
    while (n_items < stop_at - pending_views.size() && n_items < stop_at) begin
      if (with_idle) begin
        src_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en  = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise: any code, any payload
        push_cmd(random_fields(sfs_pkg::CMD_W'($urandom)));
        n_items++;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          send_simple(sfs_pkg::CMD_CLEAR);
          n_items++;
        end
        nf = ($urandom_range(0, 15) == 0) ? $urandom_range(1, sfs_pkg::FRAMES)
                                          : $urandom_range(1, 6);
        repeat (nf) send_append(pick_delay(), {$urandom, $urandom});
        send_repeats(pick_repeats());
        send_simple(sfs_pkg::CMD_RESTART);
        n_play = $urandom_range(5, 40);
        repeat (n_play) push_cmd(play_item(nf));
        n_items += nf + n_play + 2;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checking
  // ---------------------------------------------------------------------------

  initial begin
    out_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Each result transfer against the oldest expected view
  always @(posedge clk) begin : result_check
    frame_view_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_views.size() == 0) begin
        $error("result transfer with no command outstanding");
        fail_count++;
      end else begin
        want = pending_views.pop_front();
        check_field("current_frame", 32'(want.frame), 32'(out_if.current_frame));
        check_field("shown_x", 32'(want.rect.x), 32'(out_if.shown_x));
        check_field("shown_y", 32'(want.rect.y), 32'(out_if.shown_y));
        check_field("shown_w", 32'(want.rect.w), 32'(out_if.shown_w));
        check_field("shown_h", 32'(want.rect.h), 32'(out_if.shown_h));
        check_field("frame_total", 32'(want.total), 32'(out_if.frame_total));
        check_field("is_paused", 32'(want.paused), 32'(out_if.is_paused));
        check_field("is_done", 32'(want.done), 32'(out_if.is_done));
        check_field("frame_advanced", 32'(want.advanced), 32'(out_if.frame_advanced));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.cmd          = '0;
    in_if.frame_number = '0;
    in_if.frame_delay  = '0;
    in_if.src_x        = '0;
    in_if.src_y        = '0;
    in_if.src_w        = '0;
    in_if.src_h        = '0;
    in_if.repeat_value = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    wait_drain();
    test_playback();
    wait_drain();
    test_full_table();
    wait_drain();
    test_backpressure();
    wait_drain();
    test_random_play(850, 1'b1);
    wait_drain();
    // closing stretch at full rate on both sides
    src_idle_en = 1'b0;
    rx_idle_en  = 1'b0;
    test_random_play(250, 1'b0);
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
